### sv/swpmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack package
// Operation codes, status codes, field widths and sequencer states shared by
// the LIFO stack with peek, maximum and minimum.
// ----------------------------------------------------------------------------
package swpmm_pkg;

    localparam int WORD_W    = 32;
    localparam int KIND_W    = 3;
    localparam int PEEK_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 64;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [KIND_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [KIND_W-1:0] OP_POP   = 3'd1;
    localparam logic [KIND_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [KIND_W-1:0] OP_PEEK  = 3'd3;
    localparam logic [KIND_W-1:0] OP_MAX   = 3'd4;
    localparam logic [KIND_W-1:0] OP_MIN   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADPEEK = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

### sv/swpmm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module swpmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### sv/stack_with_peek_min_max.sv
`default_nettype none
// Push, pop, clear and unused codes: result valid in the cycle after acceptance.
// Peek: one registered RAM read in the read state, then the result in the response state.
// Maximum and minimum: the scan state walks the entries in turn with the
// single RAM read port and one signed comparator, then the result is presented.
// One transaction at a time: the next item is taken the cycle after the result.
// Reset clears the entry count and sequencer; the word RAM is not cleared.
// ----------------------------------------------------------------------------
// LIFO stack with peek, maximum and minimum
// Fixed-depth stack of signed words held in a RAM, run by a small sequencer.
// ----------------------------------------------------------------------------
module stack_with_peek_min_max #(
    parameter int DEPTH = swpmm_pkg::DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // push_value [31:0], peek_depth [37:32], zero fill [39:38]
    input  wire logic [swpmm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind [2:0]
    input  wire logic [swpmm_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // result_value [31:0], entry_count [38:32], status [40:39], zero fill [47:41]
    output logic      [swpmm_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > swpmm_pkg::PEEK_W) ? CW : swpmm_pkg::PEEK_W;
    localparam int WW = swpmm_pkg::WORD_W;
    localparam int EW = swpmm_pkg::COUNT_W;
    localparam int TW = swpmm_pkg::WORD_W + swpmm_pkg::COUNT_W + swpmm_pkg::STATUS_W;

    swpmm_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          first_reg, first_next;
    logic          want_max_reg, want_max_next;
    logic [WW-1:0] best_reg, best_next;
    logic [WW-1:0] result_value_reg, result_value_next;
    logic [swpmm_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [WW-1:0] push_value;
    logic [swpmm_pkg::PEEK_W-1:0] peek_depth;
    logic [PW-1:0] peek_ext;
    logic [PW-1:0] count_ext;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;
    logic          better;
    logic [WW-1:0] candidate;

    assign push_value = s_axis_tdata[WW-1:0];
    assign peek_depth = s_axis_tdata[WW +: swpmm_pkg::PEEK_W];
    assign peek_ext   = PW'(peek_depth);
    assign count_ext  = PW'(count_reg);

    swpmm_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (AW'(count_reg)),
        .wr_data (push_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // The first entry seeds the running extreme; later ones replace it on a strict win.
    assign better    = want_max_reg ? ($signed(ram_rdata) > $signed(best_reg))
                                    : ($signed(ram_rdata) < $signed(best_reg));
    assign candidate = (first_reg || better) ? ram_rdata : best_reg;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        scan_next         = scan_reg;
        first_next        = first_reg;
        want_max_next     = want_max_reg;
        best_next         = best_reg;
        result_value_next = result_value_reg;
        status_next       = status_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = '0;
        s_axis_tready     = 1'b0;
        m_axis_tvalid     = 1'b0;

        case (state_reg)
            swpmm_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    result_value_next = '0;
                    status_next       = swpmm_pkg::STAT_OK;
                    state_next        = swpmm_pkg::ST_RESP;
                    case (s_axis_tuser)
                        swpmm_pkg::OP_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = swpmm_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        swpmm_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = swpmm_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        swpmm_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        swpmm_pkg::OP_PEEK:
                        begin
                            if (peek_ext >= count_ext)
                            begin
                                status_next = swpmm_pkg::STAT_BADPEEK;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(count_ext - peek_ext - PW'(1));
                                state_next = swpmm_pkg::ST_READ;
                            end
                        end
                        swpmm_pkg::OP_MAX,
                        swpmm_pkg::OP_MIN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = swpmm_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = '0;
                                scan_next     = CW'(1);
                                first_next    = 1'b1;
                                want_max_next = (s_axis_tuser == swpmm_pkg::OP_MAX);
                                state_next    = swpmm_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = swpmm_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            swpmm_pkg::ST_READ:
            begin
                result_value_next = ram_rdata;
                state_next        = swpmm_pkg::ST_RESP;
            end
            swpmm_pkg::ST_SCAN:
            begin
                // Read data belongs to entry scan_reg - 1; the next read is issued alongside.
                best_next  = candidate;
                first_next = 1'b0;
                if (scan_reg == count_reg)
                begin
                    result_value_next = candidate;
                    state_next        = swpmm_pkg::ST_RESP;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(scan_reg);
                    scan_next = scan_reg + CW'(1);
                end
            end
            swpmm_pkg::ST_RESP:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    state_next = swpmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swpmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= swpmm_pkg::ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            first_reg    <= 1'b0;
            want_max_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            first_reg    <= first_next;
            want_max_reg <= want_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg         <= best_next;
        result_value_reg <= result_value_next;
        status_reg       <= status_next;
    end

    assign m_axis_tdata = {
        (swpmm_pkg::M_TDATA_W - TW)'(0),
        status_reg,
        EW'(count_reg),
        result_value_reg
    };

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the stack depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == swpmm_pkg::OP_POP
            && count_reg != '0)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not lower the entry count by one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swpmm_pkg::ST_SCAN) |-> (scan_reg != '0 && scan_reg <= count_reg))
        else $error("scan pointer outside the stored entries");
`endif

endmodule
`default_nettype wire

### tb/stack_with_peek_min_max_test.sv
// ----------------------------------------------------------------------------
// Stack with peek, maximum and minimum: testbench
// Streams push, pop, clear, peek, maximum, minimum and the two unused operation
// codes into the stack with random gaps on both sides. A shadow copy of the
// stack predicts every result, and each returned field is compared in order.
// ----------------------------------------------------------------------------
module stack_with_peek_min_max_test;

    localparam int WORD_W   = swpmm_pkg::WORD_W;
    localparam int KIND_W   = swpmm_pkg::KIND_W;
    localparam int PEEK_W   = swpmm_pkg::PEEK_W;
    localparam int COUNT_W  = swpmm_pkg::COUNT_W;
    localparam int STATUS_W = swpmm_pkg::STATUS_W;

    localparam int STACK_DEPTH  = swpmm_pkg::DEPTH_DEF;
    localparam int MAX_WAIT     = 18;
    localparam int QUIET_RUN    = 30;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = STACK_DEPTH + 16;
    localparam int RANDOM_ITEMS = 410;

    // Field positions in the result tdata.
    localparam int COUNT_LSB  = WORD_W;
    localparam int STATUS_LSB = WORD_W + COUNT_W;

    // The two operation codes that the block treats as no operation.
    localparam logic [KIND_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] push_value;
        logic [PEEK_W-1:0]        peek_depth;
        bit                       wait_drain;
    } stack_op_t;

    typedef struct {
        logic signed [WORD_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        logic [STATUS_W-1:0]      status;
    } stack_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [swpmm_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [KIND_W-1:0]               s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [swpmm_pkg::M_TDATA_W-1:0] m_axis_tdata;

    stack_op_t     pending_ops[$];
    stack_result_t expected_results[$];
    stack_op_t     offered_op;

    // Shadow copy of the stack.
    logic signed [WORD_W-1:0] shadow_words [STACK_DEPTH];
    int shadow_fill = 0;

    int gen_fill = 0;
    int items_queued = 0;
    int items_taken = 0;
    int results_checked = 0;
    int error_count = 0;
    int idle_cycles = 0;
    bit in_fire = 1'b0;
    bit out_fire = 1'b0;

    int send_gap = 0;
    int send_quiet = 0;
    int recv_stall = 0;
    int recv_quiet = 0;
    int hold_left = 0;
    bit held_once = 1'b0;

    int kind_tally [8] = '{default: 0};
    int full_pushes = 0;
    int empty_hits = 0;
    int bad_peeks = 0;
    int peak_fill = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    stack_with_peek_min_max #(
        .DEPTH(STACK_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic stack_result_t apply_stack_op(input stack_op_t op);
        stack_result_t r;
        logic signed [WORD_W-1:0] best;
        int i;
        r.value = '0;
        r.status = swpmm_pkg::STAT_OK;
        kind_tally[op.kind]++;
        case (op.kind)
            swpmm_pkg::OP_PUSH:
                if (shadow_fill >= STACK_DEPTH)
                begin
                    r.status = swpmm_pkg::STAT_FULL;
                    full_pushes++;
                end
                else
                begin
                    shadow_words[shadow_fill] = op.push_value;
                    shadow_fill++;
                end
            swpmm_pkg::OP_POP:
                if (shadow_fill == 0)
                begin
                    r.status = swpmm_pkg::STAT_EMPTY;
                    empty_hits++;
                end
                else
                begin
                    shadow_fill--;
                end
            swpmm_pkg::OP_CLEAR:
                shadow_fill = 0;
            swpmm_pkg::OP_PEEK:
                if (int'(op.peek_depth) >= shadow_fill)
                begin
                    r.status = swpmm_pkg::STAT_BADPEEK;
                    bad_peeks++;
                end
                else
                begin
                    r.value = shadow_words[shadow_fill - 1 - int'(op.peek_depth)];
                end
            swpmm_pkg::OP_MAX, swpmm_pkg::OP_MIN:
                if (shadow_fill == 0)
                begin
                    r.status = swpmm_pkg::STAT_EMPTY;
                    empty_hits++;
                end
                else
                begin
                    best = shadow_words[0];
                    for (i = 1; i < shadow_fill; i++)
                    begin
                        if (op.kind == swpmm_pkg::OP_MAX ? shadow_words[i] > best
                                                         : shadow_words[i] < best)
                            best = shadow_words[i];
                    end
                    r.value = best;
                end
            default: ;
        endcase
        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
        r.count = COUNT_W'(shadow_fill);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("MISMATCH at %0t, result %0d: %s got %h, expected %h",
                 $time, results_checked, what, got, want);
        error_count++;
    endtask

    task automatic add_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
                          input logic [PEEK_W-1:0] depth, input bit drain = 1'b0);
        stack_op_t op;
        op.kind = kind;
        op.push_value = word;
        op.peek_depth = depth;
        op.wait_drain = drain;
        pending_ops.push_back(op);
        items_queued++;
        case (kind)
            swpmm_pkg::OP_PUSH:  if (gen_fill < STACK_DEPTH) gen_fill++;
            swpmm_pkg::OP_POP:   if (gen_fill > 0) gen_fill--;
            swpmm_pkg::OP_CLEAR: gen_fill = 0;
            default: ;
        endcase
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4: return $urandom_range(0, 40) - 20;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [PEEK_W-1:0] any_depth();
        return PEEK_W'($urandom());
    endfunction

    // Mostly depths that hit a stored entry, sometimes any depth at all.
    function automatic logic [PEEK_W-1:0] pick_depth();
        if (gen_fill > 0 && $urandom_range(0, 4) != 0)
            return PEEK_W'($urandom_range(0, gen_fill - 1));
        return PEEK_W'($urandom_range(0, STACK_DEPTH - 1));
    endfunction

    task automatic add_random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38)
            add_op(swpmm_pkg::OP_PUSH, pick_word(), any_depth());
        else if (r < 55)
            add_op(swpmm_pkg::OP_POP, $urandom(), any_depth());
        else if (r < 75)
            add_op(swpmm_pkg::OP_PEEK, $urandom(), pick_depth());
        else if (r < 85)
            add_op(swpmm_pkg::OP_MAX, $urandom(), any_depth());
        else if (r < 95)
            add_op(swpmm_pkg::OP_MIN, $urandom(), any_depth());
        else if (r < 97)
            add_op(swpmm_pkg::OP_CLEAR, $urandom(), any_depth());
        else
            add_op($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, $urandom(), any_depth());
    endtask

    // Fill to the top, push past it, scan the full stack, peek at the bottom and back off a little.
    task automatic add_fill_run();
        while (gen_fill < STACK_DEPTH)
            add_op(swpmm_pkg::OP_PUSH, pick_word(), any_depth());
        repeat ($urandom_range(1, 3))
            add_op(swpmm_pkg::OP_PUSH, pick_word(), any_depth());
        add_op(swpmm_pkg::OP_MAX, $urandom(), any_depth());
        add_op(swpmm_pkg::OP_MIN, $urandom(), any_depth());
        add_op(swpmm_pkg::OP_PEEK, $urandom(), PEEK_W'(STACK_DEPTH - 1));
        repeat ($urandom_range(1, 8))
            add_op(swpmm_pkg::OP_POP, $urandom(), any_depth());
    endtask

    // Input side: one item in flight, a random gap drawn after each transaction.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                if (send_quiet > 0)
                begin
                    send_quiet--;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = $urandom_range(0, MAX_WAIT);
                    if ($urandom_range(0, 24) == 0)
                        send_quiet = QUIET_RUN;
                end
            end
            if (s_axis_tvalid && !in_fire)
            begin
                // Keep offering the same item until it is taken.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_ops.size() != 0
                     && !(pending_ops[0].wait_drain && expected_results.size() != 0))
            begin
                offered_op = pending_ops.pop_front();
                s_axis_tdata <= {2'b00, offered_op.peek_depth, offered_op.push_value};
                s_axis_tuser <= offered_op.kind;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random stall per result, plus one long hold-off mid-run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!held_once && results_checked >= 150)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (out_fire)
            begin
                if (recv_quiet > 0)
                begin
                    recv_quiet--;
                    recv_stall = 0;
                end
                else
                begin
                    recv_stall = $urandom_range(0, MAX_WAIT);
                    if ($urandom_range(0, 24) == 0)
                        recv_quiet = QUIET_RUN;
                end
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= (recv_stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        stack_result_t want;
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire)
        begin
            expected_results.push_back(apply_stack_op(offered_op));
            items_taken++;
        end
        if (out_fire)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with none pending", m_axis_tdata[WORD_W-1:0], '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[WORD_W-1:0] !== want.value)
                    report_mismatch("result_value", m_axis_tdata[WORD_W-1:0], want.value);
                if (m_axis_tdata[COUNT_LSB +: COUNT_W] !== want.count)
                    report_mismatch("entry_count",
                                    WORD_W'(m_axis_tdata[COUNT_LSB +: COUNT_W]),
                                    WORD_W'(want.count));
                if (m_axis_tdata[STATUS_LSB +: STATUS_W] !== want.status)
                    report_mismatch("status",
                                    WORD_W'(m_axis_tdata[STATUS_LSB +: STATUS_W]),
                                    WORD_W'(want.status));
            end
            results_checked++;
        end
        if (in_fire || out_fire || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d results still pending",
                     STALL_LIMIT, expected_results.size());
            $display("stack_with_peek_min_max_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int directed_items;
        bit mid_drain;
        mid_drain = 1'b0;

        // Empty stack: every error path and the unused codes.
        add_op(swpmm_pkg::OP_POP, '0, '0);
        add_op(swpmm_pkg::OP_MAX, '0, '0);
        add_op(swpmm_pkg::OP_MIN, '1, '1);
        add_op(swpmm_pkg::OP_PEEK, '1, '0);
        add_op(OP_SPARE_LO, '1, '1);
        add_op(OP_SPARE_HI, '0, '0);
        // Signed extremes, then peeks at the top, the bottom and past it.
        add_op(swpmm_pkg::OP_PUSH, 32'h7FFF_FFFF, '1);
        add_op(swpmm_pkg::OP_PUSH, 32'h8000_0000, '0);
        add_op(swpmm_pkg::OP_PUSH, '0, '0);
        add_op(swpmm_pkg::OP_PUSH, '1, '0);
        add_op(swpmm_pkg::OP_PEEK, '0, 6'd0);
        add_op(swpmm_pkg::OP_PEEK, '0, 6'd3);
        add_op(swpmm_pkg::OP_PEEK, '0, 6'd4);
        add_op(swpmm_pkg::OP_PEEK, '1, 6'd63);
        add_op(swpmm_pkg::OP_MAX, '0, '0);
        add_op(swpmm_pkg::OP_MIN, '0, '0);
        add_op(OP_SPARE_HI, '1, '1);
        add_op(swpmm_pkg::OP_POP, '0, '0);
        add_op(swpmm_pkg::OP_MAX, '0, '0);
        add_op(swpmm_pkg::OP_CLEAR, '1, '1);
        add_op(swpmm_pkg::OP_PEEK, '0, '0);
        add_op(swpmm_pkg::OP_PUSH, 32'h8000_0000, '0);
        add_op(swpmm_pkg::OP_MIN, '0, '0);
        add_op(swpmm_pkg::OP_CLEAR, '0, '0);
        directed_items = items_queued;

        add_op(swpmm_pkg::OP_MAX, $urandom(), any_depth(), 1'b1);
        while (items_queued < directed_items + RANDOM_ITEMS)
        begin
            if (!mid_drain && items_queued >= directed_items + 200)
            begin
                add_op(swpmm_pkg::OP_PEEK, $urandom(), pick_depth(), 1'b1);
                mid_drain = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: add_fill_run();
                1: add_op(swpmm_pkg::OP_CLEAR, $urandom(), any_depth());
                default: repeat (8) add_random_op();
            endcase
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (items_taken != items_queued || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions: %0d push, %0d pop, %0d clear, %0d peek,",
                 items_taken, kind_tally[swpmm_pkg::OP_PUSH], kind_tally[swpmm_pkg::OP_POP],
                 kind_tally[swpmm_pkg::OP_CLEAR], kind_tally[swpmm_pkg::OP_PEEK]);
        $display("  %0d max, %0d min, %0d unused code; full pushes %0d, empty errors %0d,",
                 kind_tally[swpmm_pkg::OP_MAX], kind_tally[swpmm_pkg::OP_MIN],
                 kind_tally[OP_SPARE_LO] + kind_tally[OP_SPARE_HI],
                 full_pushes, empty_hits);
        $display("  bad peek depths %0d, deepest fill %0d", bad_peeks, peak_fill);
        if (error_count == 0)
            $display("stack_with_peek_min_max_test: done, clean");
        else
            $display("stack_with_peek_min_max_test: done, errors");
        $finish;
    end

endmodule
